### rtl/nbs3_pkg.sv
// Package for the 3x3 neighborhood sum block: sizes, register indexes and the result record.
// Depends on nothing; every other file of the block except nbs3_ram refers to it by scoped names.
package nbs3_pkg;

    localparam int MAX_WIDTH      = 32;
    localparam int PIXEL_BITS     = 16;
    localparam int COL_BITS       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIDTH_BITS     = 6;
    localparam int HEIGHT_BITS    = 12;
    localparam int ROW_BITS       = 12;
    localparam int OUT_COL_BITS   = 5;
    localparam int SUM_BITS       = 20;
    localparam int COLSUM_BITS    = PIXEL_BITS + 2;
    localparam int LINE_BITS      = 2 * PIXEL_BITS;

    localparam int MAX_RESULTS    = 4;
    localparam int PUSH_CNT_BITS  = $clog2(MAX_RESULTS + 1);
    localparam int FIFO_DEPTH     = 2 * MAX_RESULTS;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;

    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [WIDTH_BITS-1:0]  RESET_FRAME_WIDTH  = 6'd7;
    localparam logic [HEIGHT_BITS-1:0] RESET_FRAME_HEIGHT = 12'd5;

    // Register index, taken from address bit 2.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] neighborhood_sum;
        logic [ROW_BITS-1:0]        out_row;
        logic [OUT_COL_BITS-1:0]    out_col;
        logic                       last_of_run;
        logic                       end_of_frame;
    } result_t;

endpackage

### rtl/nbs3_if.sv
// Stream interfaces of the 3x3 neighborhood sum block: pixel requests in, sum requests out.
// Depends on nbs3_pkg for the field widths.
interface nbs3_pixel_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [nbs3_pkg::PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface nbs3_sum_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [nbs3_pkg::SUM_BITS-1:0] neighborhood_sum;
    logic [nbs3_pkg::ROW_BITS-1:0]        out_row;
    logic [nbs3_pkg::OUT_COL_BITS-1:0]    out_col;
    logic                                 last_of_run;
    logic                                 end_of_frame;

    modport source (output valid, output neighborhood_sum, output out_row, output out_col,
                    output last_of_run, output end_of_frame, input ready);
    modport sink   (input valid, input neighborhood_sum, input out_row, input out_col,
                    input last_of_run, input end_of_frame, output ready);
endinterface

### rtl/nbs3_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; a read of the address being written returns the old contents.
module nbs3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nbs3_result_fifo.sv
// Result queue of the 3x3 neighborhood sum block: takes up to four results a cycle, gives one.
// Depends on nbs3_pkg for the result record and the queue sizes.
module nbs3_result_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [nbs3_pkg::MAX_RESULTS-1:0]     push_valid,
    input  nbs3_pkg::result_t                    push_data [nbs3_pkg::MAX_RESULTS],
    input  logic                                 pop,
    output logic                                 out_valid,
    output nbs3_pkg::result_t                    out_data,
    output logic [nbs3_pkg::FIFO_CNT_BITS-1:0]   count
);

    nbs3_pkg::result_t                        entry_reg [nbs3_pkg::FIFO_DEPTH];
    logic [nbs3_pkg::FIFO_PTR_BITS-1:0]       wr_ptr_reg;
    logic [nbs3_pkg::FIFO_PTR_BITS-1:0]       rd_ptr_reg;
    logic [nbs3_pkg::FIFO_CNT_BITS-1:0]       count_reg;
    logic [nbs3_pkg::FIFO_CNT_BITS-1:0]       count_next;
    logic [nbs3_pkg::PUSH_CNT_BITS-1:0]       offset [nbs3_pkg::MAX_RESULTS];
    logic [nbs3_pkg::PUSH_CNT_BITS-1:0]       push_num;
    logic                                     do_pop;

    // Valid results are packed together in order, so each one goes to the write
    // pointer plus the number of valid results ahead of it.
    always_comb
    begin : prefix_count
        logic [nbs3_pkg::PUSH_CNT_BITS-1:0] acc;
        acc = '0;
        for (int i = 0; i < nbs3_pkg::MAX_RESULTS; i++)
        begin
            offset[i] = acc;
            acc = acc + nbs3_pkg::PUSH_CNT_BITS'(push_valid[i]);
        end
        push_num = acc;
    end

    assign out_valid = (count_reg != '0);
    assign do_pop    = pop && out_valid;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg + nbs3_pkg::FIFO_CNT_BITS'(push_num)
                   - nbs3_pkg::FIFO_CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < nbs3_pkg::MAX_RESULTS; i++)
        begin
            if (push_valid[i])
            begin
                entry_reg[nbs3_pkg::FIFO_PTR_BITS'(wr_ptr_reg
                          + nbs3_pkg::FIFO_PTR_BITS'(offset[i]))] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= nbs3_pkg::FIFO_PTR_BITS'(wr_ptr_reg
                          + nbs3_pkg::FIFO_PTR_BITS'(push_num));
            rd_ptr_reg <= nbs3_pkg::FIFO_PTR_BITS'(rd_ptr_reg
                          + nbs3_pkg::FIFO_PTR_BITS'(do_pop));
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/neighborhood_sum_3x3_core.sv
// Top level of the streaming 3x3 neighborhood sum block with clipped borders.
// Depends on nbs3_pkg, nbs3_if, nbs3_ram and nbs3_result_fifo.

// Pixels of a frame enter in row-major order, one request per cycle at most, and
// for every position the block returns the sum of the pixel and of those of its
// eight neighbors that lie inside the frame; positions outside are left out, not
// padded. A sum leaves as soon as its last pixel has arrived. Outside the bottom
// row a pixel releases nothing in the top row or at the start of a row, one sum
// elsewhere and two at the end of a row; in the bottom row a pixel releases up to
// two more, so the frame's last pixel releases at most four. Each sum carries its
// row and column, last_of_run marks the final sum released by one pixel, and
// end_of_frame marks the frame's last position. The two previous rows live in one
// 32-entry line RAM (both rows side by side in one word) that is read when a pixel
// is taken and written back in the next cycle; when the frame is one column wide
// the same entry is written and read again in the same cycle, and the write data is
// forwarded. A pixel is taken every cycle while the eight-entry result queue has
// room for a full burst of four, so the sustained rate is one pixel per cycle
// with the output taking one sum per cycle; only in the bottom row, where a pixel
// releases two sums, does the output port bound the pixel rate. frame_width (byte
// address 0) and frame_height (byte address 4) are written over the APB port; the
// user must write them only while the block is idle, which the block itself does
// not enforce. A write restarts the frame at row 0, column 0. A width of 0 acts
// as 1, above 32 as 32, and a height of 0 as 1. There is no clearing pass after
// reset: a line entry is read only after this frame has written it.
module neighborhood_sum_3x3_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    nbs3_pixel_if.sink                           pixels,
    nbs3_sum_if.source                           sums,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nbs3_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [nbs3_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [nbs3_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int PB = nbs3_pkg::PIXEL_BITS;
    localparam int CB = nbs3_pkg::COLSUM_BITS;
    localparam int SB = nbs3_pkg::SUM_BITS;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [nbs3_pkg::WIDTH_BITS-1:0]  frame_width_reg;
    logic [nbs3_pkg::HEIGHT_BITS-1:0] frame_height_reg;
    logic                             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= nbs3_pkg::RESET_FRAME_WIDTH;
            frame_height_reg <= nbs3_pkg::RESET_FRAME_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                nbs3_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= pwdata[nbs3_pkg::WIDTH_BITS-1:0];
                end
                nbs3_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= pwdata[nbs3_pkg::HEIGHT_BITS-1:0];
                end
                default:
                begin
                    frame_width_reg <= frame_width_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            nbs3_pkg::REG_FRAME_WIDTH:
            begin
                prdata = nbs3_pkg::APB_DATA_BITS'(frame_width_reg);
            end
            nbs3_pkg::REG_FRAME_HEIGHT:
            begin
                prdata = nbs3_pkg::APB_DATA_BITS'(frame_height_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // The last column and row index, with the width clamped to 1..MAX_WIDTH
    // and the height to at least 1.
    logic [nbs3_pkg::COL_BITS:0]      width_eff;
    logic [nbs3_pkg::COL_BITS-1:0]    col_last;
    logic [nbs3_pkg::ROW_BITS-1:0]    row_last;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            width_eff = (nbs3_pkg::COL_BITS + 1)'(1);
        end
        else if (int'(frame_width_reg) > nbs3_pkg::MAX_WIDTH)
        begin
            width_eff = (nbs3_pkg::COL_BITS + 1)'(nbs3_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = (nbs3_pkg::COL_BITS + 1)'(frame_width_reg);
        end
        col_last = nbs3_pkg::COL_BITS'(width_eff - 1'b1);
        row_last = (frame_height_reg == '0) ? '0
                 : nbs3_pkg::ROW_BITS'(frame_height_reg - 1'b1);
    end

    // ------------------------------------------------------------------
    // Request stage: position counters and the line RAM read.
    // ------------------------------------------------------------------
    logic                             in_accept;
    logic [nbs3_pkg::COL_BITS-1:0]    col_reg;
    logic [nbs3_pkg::COL_BITS-1:0]    col_next;
    logic [nbs3_pkg::ROW_BITS-1:0]    row_reg;
    logic [nbs3_pkg::ROW_BITS-1:0]    row_next;
    logic                             at_last_col;
    logic                             at_last_row;

    assign in_accept   = pixels.valid && pixels.ready;
    assign at_last_col = (col_reg == col_last);
    assign at_last_row = (row_reg == row_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : nbs3_pkg::ROW_BITS'(row_reg + 1'b1);
            end
            else
            begin
                col_next = nbs3_pkg::COL_BITS'(col_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Update stage: registered copy of the request and its position.
    // ------------------------------------------------------------------
    logic                             s1_valid_reg;
    logic signed [PB-1:0]             s1_pixel_reg;
    logic [nbs3_pkg::COL_BITS-1:0]    s1_col_reg;
    logic [nbs3_pkg::ROW_BITS-1:0]    s1_row_reg;
    logic                             s1_last_col_reg;
    logic                             s1_last_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg    <= pixels.pixel;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= at_last_col;
            s1_last_row_reg <= at_last_row;
        end
    end

    // Line RAM word: upper half is the row just above, lower half two rows up.
    // The update stage writes {this pixel, row above} back to the same column.
    logic [nbs3_pkg::LINE_BITS-1:0]   ram_rdata;
    logic [nbs3_pkg::LINE_BITS-1:0]   ram_wdata;
    logic [nbs3_pkg::LINE_BITS-1:0]   line_word;
    logic                             fwd_valid_reg;
    logic [nbs3_pkg::LINE_BITS-1:0]   fwd_data_reg;
    logic signed [PB-1:0]             line_newer;
    logic signed [PB-1:0]             line_older;

    nbs3_ram #(
        .WIDTH (nbs3_pkg::LINE_BITS),
        .DEPTH (nbs3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // A one-column frame reads the entry that the previous pixel writes at the
    // same edge; the RAM then returns stale data, so the write data is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= in_accept && s1_valid_reg && (col_reg == s1_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
    end

    assign line_word  = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign line_newer = line_word[nbs3_pkg::LINE_BITS-1:PB];
    assign line_older = line_word[PB-1:0];
    assign ram_wdata  = {s1_pixel_reg, line_newer};

    // ------------------------------------------------------------------
    // Column sums and the two sliding windows. The full window holds three-row
    // column sums for the row above; the low window holds two-row column sums
    // used only when this is the frame's last row.
    // ------------------------------------------------------------------
    logic signed [PB-1:0]             up_pix;
    logic signed [PB-1:0]             top_pix;
    logic signed [CB-1:0]             col_sum;
    logic signed [CB-1:0]             low_sum;
    logic                             s1_first_col;
    logic signed [CB-1:0]             win_reg [3];
    logic signed [CB-1:0]             win_next [3];
    logic signed [CB-1:0]             low_reg [3];
    logic signed [CB-1:0]             low_next [3];

    assign s1_first_col = (s1_col_reg == '0);
    assign up_pix  = (s1_row_reg != '0) ? line_newer : '0;
    assign top_pix = (s1_row_reg > nbs3_pkg::ROW_BITS'(1)) ? line_older : '0;
    assign low_sum = CB'(up_pix) + CB'(s1_pixel_reg);
    assign col_sum = CB'(top_pix) + low_sum;

    always_comb
    begin
        win_next[0] = s1_first_col ? '0 : win_reg[1];
        win_next[1] = s1_first_col ? '0 : win_reg[2];
        win_next[2] = col_sum;
        low_next[0] = s1_first_col ? '0 : low_reg[1];
        low_next[1] = s1_first_col ? '0 : low_reg[2];
        low_next[2] = low_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i] <= '0;
                low_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i] <= '0;
                low_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i] <= win_next[i];
                low_reg[i] <= low_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Results released by this pixel, in row-major order: the position up and
    // to the left, the position straight up at a row end, then in the last row
    // the position to the left and, at a row end, this position itself.
    // ------------------------------------------------------------------
    logic [nbs3_pkg::MAX_RESULTS-1:0] push_valid;
    nbs3_pkg::result_t                push_data [nbs3_pkg::MAX_RESULTS];
    logic signed [SB-1:0]             sum_full;
    logic signed [SB-1:0]             sum_pair;
    logic signed [SB-1:0]             sum_low_full;
    logic signed [SB-1:0]             sum_low_pair;
    logic [nbs3_pkg::ROW_BITS-1:0]    row_above;
    logic [nbs3_pkg::OUT_COL_BITS-1:0] col_here;
    logic [nbs3_pkg::OUT_COL_BITS-1:0] col_left;
    logic                             has_above;
    logic                             has_left;

    assign has_above    = (s1_row_reg != '0);
    assign has_left     = !s1_first_col;
    assign row_above    = nbs3_pkg::ROW_BITS'(s1_row_reg - 1'b1);
    assign col_here     = nbs3_pkg::OUT_COL_BITS'(s1_col_reg);
    assign col_left     = nbs3_pkg::OUT_COL_BITS'(nbs3_pkg::COL_BITS'(s1_col_reg - 1'b1));
    assign sum_pair     = SB'(win_next[1]) + SB'(win_next[2]);
    assign sum_full     = SB'(win_next[0]) + sum_pair;
    assign sum_low_pair = SB'(low_next[1]) + SB'(low_next[2]);
    assign sum_low_full = SB'(low_next[0]) + sum_low_pair;

    always_comb
    begin
        push_valid[0] = s1_valid_reg && has_above && has_left;
        push_valid[1] = s1_valid_reg && has_above && s1_last_col_reg;
        push_valid[2] = s1_valid_reg && s1_last_row_reg && has_left;
        push_valid[3] = s1_valid_reg && s1_last_row_reg && s1_last_col_reg;

        push_data[0].neighborhood_sum = sum_full;
        push_data[0].out_row          = row_above;
        push_data[0].out_col          = col_left;
        push_data[0].end_of_frame     = 1'b0;

        push_data[1].neighborhood_sum = sum_pair;
        push_data[1].out_row          = row_above;
        push_data[1].out_col          = col_here;
        push_data[1].end_of_frame     = 1'b0;

        push_data[2].neighborhood_sum = sum_low_full;
        push_data[2].out_row          = s1_row_reg;
        push_data[2].out_col          = col_left;
        push_data[2].end_of_frame     = 1'b0;

        push_data[3].neighborhood_sum = sum_low_pair;
        push_data[3].out_row          = s1_row_reg;
        push_data[3].out_col          = col_here;
        push_data[3].end_of_frame     = 1'b1;

        // The final valid result of the pixel closes the run.
        push_data[3].last_of_run = push_valid[3];
        push_data[2].last_of_run = push_valid[2] && !push_valid[3];
        push_data[1].last_of_run = push_valid[1] && !push_valid[2] && !push_valid[3];
        push_data[0].last_of_run = push_valid[0] && !push_valid[1] && !push_valid[2]
                                   && !push_valid[3];
    end

    // ------------------------------------------------------------------
    // Result queue and the output request.
    // ------------------------------------------------------------------
    logic                                 q_valid;
    nbs3_pkg::result_t                    q_data;
    logic [nbs3_pkg::FIFO_CNT_BITS-1:0]   q_count;

    nbs3_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (sums.ready),
        .out_valid  (q_valid),
        .out_data   (q_data),
        .count      (q_count)
    );

    // A pixel is taken only if a full burst still fits behind what is queued
    // and what the update stage pushes this cycle.
    assign pixels.ready = (int'(q_count) + $countones(push_valid))
                          <= (nbs3_pkg::FIFO_DEPTH - nbs3_pkg::MAX_RESULTS);

    assign sums.valid            = q_valid;
    assign sums.neighborhood_sum = q_data.neighborhood_sum;
    assign sums.out_row          = q_data.out_row;
    assign sums.out_col          = q_data.out_col;
    assign sums.last_of_run      = q_data.last_of_run;
    assign sums.end_of_frame     = q_data.end_of_frame;

endmodule
